### src/assert_macros.svh
// Assertion helpers for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk while the block is out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/mkds_pkg.sv
`timescale 1ns / 1ps

package mkds_pkg;

    // Default geometry of the key matrix.
    localparam int KEYS_DEFAULT    = 8;
    localparam int COLUMNS_DEFAULT = 3;
    localparam int ROWS_DEFAULT    = 6;

    // Field widths fixed by the transfer formats and the register layout.
    localparam int NOW_W        = 32;
    localparam int ROW_LEVELS_W = 18;
    localparam int KEY_INDEX_W  = 3;
    localparam int LEVELS_W     = 8;
    localparam int DEBOUNCE_W   = 16;
    localparam int MAP_ENTRIES  = 8;
    localparam int ENTRY_W      = 5;
    localparam int KEY_MAP_W    = MAP_ENTRIES * ENTRY_W;
    localparam int ROW_FIELD_W  = 3;
    localparam int COL_FIELD_W  = 2;
    // Enough for column * ROWS + row with the largest row and column fields.
    localparam int SEL_W        = 5;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = KEY_MAP_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_MS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_MAP     = 1'd1;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [KEY_MAP_W-1:0]  KEY_MAP_RESET  = 40'd317895759507;

    // Item commands.
    localparam logic CMD_SCAN  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Control handed to one key's debounce cell for the item in flight.
    typedef struct packed {
        logic                  scan_en;
        logic                  clear_en;
        logic                  reading;
        logic [NOW_W-1:0]      now_ms;
        logic [DEBOUNCE_W-1:0] debounce_ms;
    } key_ctl_t;

endpackage

### src/mkds_in_if.sv
`timescale 1ns / 1ps

interface mkds_in_if;

    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic [mkds_pkg::NOW_W-1:0]           now_ms;
    logic [mkds_pkg::ROW_LEVELS_W-1:0]    row_levels;
    logic [mkds_pkg::KEY_INDEX_W-1:0]     key_index;

    modport source (output valid, command, now_ms, row_levels, key_index, input ready);
    modport sink   (input valid, command, now_ms, row_levels, key_index, output ready);

endinterface

### src/mkds_out_if.sv
`timescale 1ns / 1ps

interface mkds_out_if;

    logic                           valid;
    logic                           ready;
    logic                           pressed;
    logic [mkds_pkg::LEVELS_W-1:0]  key_levels;

    modport source (output valid, pressed, key_levels, input ready);
    modport sink   (input valid, pressed, key_levels, output ready);

endinterface

### src/mkds_key.sv
`timescale 1ns / 1ps

// Debounce state of one key: raw level, accepted level, press flag and the
// timestamp of the last raw change.
module mkds_key
(
    input  logic               clk,
    input  logic               rst_n,
    input  mkds_pkg::key_ctl_t ctl,
    output logic               stable,
    output logic               stable_next,
    output logic               flag
);

    logic                       raw_reg;
    logic                       raw_next;
    logic                       stable_reg;
    logic                       flag_reg;
    logic                       flag_next;
    logic [mkds_pkg::NOW_W-1:0] change_time_reg;
    logic [mkds_pkg::NOW_W-1:0] change_time_next;
    logic [mkds_pkg::NOW_W-1:0] elapsed;
    logic                       changed;
    logic                       settled;

    always_comb
    begin
        changed = ctl.reading != raw_reg;
        elapsed = ctl.now_ms - change_time_reg;
        // A fresh change has zero elapsed time, so it settles only with no debounce.
        if (changed)
        begin
            settled = ctl.debounce_ms == '0;
        end
        else
        begin
            settled = elapsed >= mkds_pkg::NOW_W'(ctl.debounce_ms);
        end

        raw_next         = raw_reg;
        change_time_next = change_time_reg;
        stable_next      = stable_reg;
        flag_next        = flag_reg;

        if (ctl.scan_en)
        begin
            if (changed)
            begin
                raw_next         = ctl.reading;
                change_time_next = ctl.now_ms;
            end
            if (settled && (stable_reg != ctl.reading))
            begin
                stable_next = ctl.reading;
                if (!ctl.reading)
                begin
                    flag_next = 1'b1;
                end
            end
        end
        if (ctl.clear_en)
        begin
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg         <= 1'b1;
            stable_reg      <= 1'b1;
            flag_reg        <= 1'b0;
            change_time_reg <= '0;
        end
        else
        begin
            raw_reg         <= raw_next;
            stable_reg      <= stable_next;
            flag_reg        <= flag_next;
            change_time_reg <= change_time_next;
        end
    end

    assign stable = stable_reg;
    assign flag   = flag_reg;

endmodule

### src/matrix_key_debounce_scanner.sv
`timescale 1ns / 1ps

// Channel     Direction  Handshake      Payload
// scan_in     in         valid/ready    command, now_ms, row_levels, key_index
// result_out  out        valid/ready    pressed, key_levels
// config      in         cfg_we         cfg_index, cfg_data (write only)
//
// Each item passes through the input register and then the result register on its way
// to its result. A new item is accepted every cycle while result_out takes results;
// the per-key update between the two registers is combinational.
// Reset is asynchronous and active low and takes effect at once; no clearing pass.
// A stall on result_out holds the result and the item behind it, and scan_in
// drops ready only when both stages are full.

`include "assert_macros.svh"

module matrix_key_debounce_scanner
#(
    parameter int KEYS    = mkds_pkg::KEYS_DEFAULT,
    parameter int COLUMNS = mkds_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = mkds_pkg::ROWS_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mkds_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mkds_pkg::CFG_DATA_W-1:0]     cfg_data,
    mkds_in_if.sink                             scan_in,
    mkds_out_if.source                          result_out
);

    // Configuration registers.
    logic [mkds_pkg::DEBOUNCE_W-1:0] debounce_ms_reg;
    logic [mkds_pkg::KEY_MAP_W-1:0]  key_map_reg;

    // Input stage.
    logic                                s1_valid_reg;
    logic                                s1_command_reg;
    logic [mkds_pkg::NOW_W-1:0]          s1_now_ms_reg;
    logic [mkds_pkg::ROW_LEVELS_W-1:0]   s1_row_levels_reg;
    logic [mkds_pkg::KEY_INDEX_W-1:0]    s1_key_index_reg;
    logic                                s1_advance;
    logic                                in_accept;

    // Result stage.
    logic                                out_valid_reg;
    logic                                pressed_reg;
    logic                                pressed_next;
    logic [mkds_pkg::LEVELS_W-1:0]       key_levels_reg;

    // Per-key state views.
    logic [KEYS-1:0]                     stable_vec;
    logic [KEYS-1:0]                     stable_next_vec;
    logic [KEYS-1:0]                     flag_vec;
    logic [mkds_pkg::LEVELS_W-1:0]       stable8;
    logic [mkds_pkg::LEVELS_W-1:0]       stable_next8;
    logic [mkds_pkg::LEVELS_W-1:0]       flag8;

    logic scan_go;
    logic query_go;

    // The input stage moves on whenever the result register is free or being taken.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || result_out.ready);
    assign scan_in.ready = !s1_valid_reg || s1_advance;
    assign in_accept = scan_in.valid && scan_in.ready;

    assign scan_go  = s1_advance && (s1_command_reg == mkds_pkg::CMD_SCAN);
    assign query_go = s1_advance && (s1_command_reg == mkds_pkg::CMD_QUERY);

    // Configuration writes; an index beyond the list is ignored by construction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg <= mkds_pkg::DEBOUNCE_RESET;
            key_map_reg     <= mkds_pkg::KEY_MAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mkds_pkg::CFG_DEBOUNCE_MS:
                begin
                    debounce_ms_reg <= cfg_data[mkds_pkg::DEBOUNCE_W-1:0];
                end
                mkds_pkg::CFG_KEY_MAP:
                begin
                    key_map_reg <= cfg_data[mkds_pkg::KEY_MAP_W-1:0];
                end
                default:
                begin
                    debounce_ms_reg <= debounce_ms_reg;
                end
            endcase
        end
    end

    // Input register: the valid flag is control, the payload loads on each transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (scan_in.ready)
        begin
            s1_valid_reg <= scan_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_command_reg    <= scan_in.command;
            s1_now_ms_reg     <= scan_in.now_ms;
            s1_row_levels_reg <= scan_in.row_levels;
            s1_key_index_reg  <= scan_in.key_index;
        end
    end

    // One debounce cell per key. Keys without a map entry, and keys mapped
    // outside the matrix, are never touched by a scan and keep their state.
    for (genvar k = 0; k < KEYS; k++)
    begin : g_key
        logic                              in_scope;
        logic                              reading;
        mkds_pkg::key_ctl_t                ctl;

        if (k < mkds_pkg::MAP_ENTRIES)
        begin : g_mapped
            logic [mkds_pkg::ENTRY_W-1:0]      entry;
            logic [mkds_pkg::ROW_FIELD_W-1:0]  row;
            logic [mkds_pkg::COL_FIELD_W-1:0]  col;
            logic [mkds_pkg::SEL_W-1:0]        sel;

            assign entry = key_map_reg[mkds_pkg::ENTRY_W*k +: mkds_pkg::ENTRY_W];
            assign row   = entry[mkds_pkg::ROW_FIELD_W-1:0];
            assign col   = entry[mkds_pkg::ENTRY_W-1:mkds_pkg::ROW_FIELD_W];
            assign sel   = mkds_pkg::SEL_W'(col) * mkds_pkg::SEL_W'(ROWS)
                         + mkds_pkg::SEL_W'(row);
            assign in_scope = (int'(row) < ROWS) && (int'(col) < COLUMNS)
                            && (int'(sel) < mkds_pkg::ROW_LEVELS_W);
            assign reading  = in_scope ? s1_row_levels_reg[sel] : 1'b1;
        end
        else
        begin : g_unmapped
            assign in_scope = 1'b0;
            assign reading  = 1'b1;
        end

        assign ctl.scan_en     = scan_go && in_scope;
        assign ctl.clear_en    = query_go && (int'(s1_key_index_reg) == k);
        assign ctl.reading     = reading;
        assign ctl.now_ms      = s1_now_ms_reg;
        assign ctl.debounce_ms = debounce_ms_reg;

        mkds_key u_key
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .stable      (stable_vec[k]),
            .stable_next (stable_next_vec[k]),
            .flag        (flag_vec[k])
        );
    end

    // Result-width views; keys beyond KEYS read as zero.
    for (genvar i = 0; i < mkds_pkg::LEVELS_W; i++)
    begin : g_view
        if (i < KEYS)
        begin : g_present
            assign stable8[i]      = stable_vec[i];
            assign stable_next8[i] = stable_next_vec[i];
            assign flag8[i]        = flag_vec[i];
        end
        else
        begin : g_absent
            assign stable8[i]      = 1'b0;
            assign stable_next8[i] = 1'b0;
            assign flag8[i]        = 1'b0;
        end
    end

    // A query returns the flag as it stood before the clear; a scan returns zero.
    assign pressed_next = (s1_command_reg == mkds_pkg::CMD_QUERY) ?
                          flag8[s1_key_index_reg] : 1'b0;

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            pressed_reg    <= pressed_next;
            key_levels_reg <= stable_next8;
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.pressed    = pressed_reg;
    assign result_out.key_levels = key_levels_reg;

    // An item waiting behind a stalled result is never dropped.
    `ASSERT_CLK(a_stage_holds, s1_valid_reg && !s1_advance |=> s1_valid_reg, "item lost in input stage")

    // A query leaves the asked key's press flag clear.
    `ASSERT_CLK(a_query_clears, query_go |=> !flag8[$past(s1_key_index_reg)], "press flag not cleared")

    // Every key whose debounced level has just fallen has its press flag set.
    `ASSERT_CLK(a_fall_flags, ($past(stable8) & ~stable8 & ~flag8) == '0, "fall without press flag")

    // No result can appear while reset is held.
    `ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !result_out.valid, "result during reset")

endmodule

### bench/mkds_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, keeps its own copy of the key state and
// checks every result transfer against the oldest prediction still waiting.
module mkds_checker
    import mkds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    mkds_in_if                     scan_in,
    mkds_out_if                    result_out,
    output int                     fail_count,
    output int                     pending_count
);

    typedef struct packed {
        logic                pressed;
        logic [LEVELS_W-1:0] key_levels;
    } key_result_t;

    key_result_t expected_results[$];

    logic [DEBOUNCE_W-1:0]     hold_ms;
    logic [KEY_MAP_W-1:0]      position_map;
    logic [KEYS_DEFAULT-1:0]   raw_bits;
    logic [KEYS_DEFAULT-1:0]   stable_bits;
    logic [KEYS_DEFAULT-1:0]   press_bits;
    logic [NOW_W-1:0]          change_stamp [KEYS_DEFAULT];

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    task automatic report_failure(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        fail_count++;
    endtask

    // Applies one item to the key state and returns the result it should produce.
    function automatic key_result_t debounce_item(
        input logic                    cmd,
        input logic [NOW_W-1:0]        now,
        input logic [ROW_LEVELS_W-1:0] rows,
        input logic [KEY_INDEX_W-1:0]  idx
    );
        key_result_t            res;
        logic [ENTRY_W-1:0]     entry;
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
        logic                   reading;
        logic [NOW_W-1:0]       held;
        res.pressed = 1'b0;
        if (cmd == CMD_SCAN)
        begin
            for (int k = 0; k < KEYS_DEFAULT; k++)
            begin
                entry = position_map[ENTRY_W*k +: ENTRY_W];
                row   = entry[ROW_FIELD_W-1:0];
                col   = entry[ENTRY_W-1 -: COL_FIELD_W];
                if (row < ROWS_DEFAULT && col < COLUMNS_DEFAULT)
                begin
                    reading = rows[col*ROWS_DEFAULT + row];
                    if (reading != raw_bits[k])
                    begin
                        change_stamp[k] = now;
                        raw_bits[k]     = reading;
                    end
                    held = now - change_stamp[k];
                    if (held >= hold_ms && stable_bits[k] != reading)
                    begin
                        stable_bits[k] = reading;
                        if (reading == 1'b0)
                            press_bits[k] = 1'b1;
                    end
                end
            end
        end
        else if (idx < KEYS_DEFAULT)
        begin
            res.pressed     = press_bits[idx];
            press_bits[idx] = 1'b0;
        end
        res.key_levels = stable_bits;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        key_result_t got;
        key_result_t want;
        if (!rst_n)
        begin
            hold_ms      = DEBOUNCE_RESET;
            position_map = KEY_MAP_RESET;
            raw_bits     = '1;
            stable_bits  = '1;
            press_bits   = '0;
            for (int k = 0; k < KEYS_DEFAULT; k++)
                change_stamp[k] = '0;
            expected_results.delete();
            pending_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_DEBOUNCE_MS)
                    hold_ms = cfg_data[DEBOUNCE_W-1:0];
                else if (cfg_index == CFG_KEY_MAP)
                    position_map = cfg_data[KEY_MAP_W-1:0];
            end
            if (scan_in.valid && scan_in.ready)
                expected_results.push_back(debounce_item(scan_in.command, scan_in.now_ms,
                                                         scan_in.row_levels, scan_in.key_index));
            if (result_out.valid && result_out.ready)
            begin
                got.pressed    = result_out.pressed;
                got.key_levels = result_out.key_levels;
                if (expected_results.size() == 0)
                    report_failure($sformatf("result transfer with nothing expected (%0h)", got));
                else
                begin
                    want = expected_results.pop_front();
                    if (got.pressed !== want.pressed)
                        report_failure($sformatf("pressed expected %0b, got %0b",
                                                 want.pressed, got.pressed));
                    if (got.key_levels !== want.key_levels)
                        report_failure($sformatf("key_levels expected %02h, got %02h",
                                                 want.key_levels, got.key_levels));
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the key scanner. The checker beside the block does all the
// prediction; this module only produces transfers, register writes and back-pressure.
module testbench;

    import mkds_pkg::*;

    // Generous bound on the run of roughly 750 items, each of which may wait out a sender
    // gap and a long receiver stall.
    localparam int CYCLE_LIMIT     = 400000;
    // Length of the deliberate receiver hold-off that fills the block up.
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int PHASES          = 6;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending_count;
    int cycle_count = 0;

    // Raised by the stimulus, cleared by the receiver process once it starts holding off.
    bit hold_off_request = 1'b0;

    // The stimulus's own notion of the configuration and of the physical contacts, used
    // only to shape the timestamps and row patterns so that keys really do settle.
    logic [DEBOUNCE_W-1:0]   debounce_now;
    logic [KEY_MAP_W-1:0]    map_now;
    logic [NOW_W-1:0]        scan_clock_ms;
    logic [ROW_LEVELS_W-1:0] contact_rows;

    mkds_in_if  scan_ch ();
    mkds_out_if result_ch ();

    matrix_key_debounce_scanner u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .scan_in    (scan_ch),
        .result_out (result_ch)
    );

    mkds_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .scan_in       (scan_ch),
        .result_out    (result_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Watchdog: a hung handshake or a result that never arrives ends up here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one item at the falling edge and holds it until the block takes it. The valid
    // line is left high, so back-to-back calls give an unbroken burst of transfers.
    task automatic offer_item(
        input logic                    cmd,
        input logic [NOW_W-1:0]        now,
        input logic [ROW_LEVELS_W-1:0] rows,
        input logic [KEY_INDEX_W-1:0]  idx
    );
        @(negedge clk);
        scan_ch.valid      <= 1'b1;
        scan_ch.command    <= cmd;
        scan_ch.now_ms     <= now;
        scan_ch.row_levels <= rows;
        scan_ch.key_index  <= idx;
        do
            @(posedge clk);
        while (!scan_ch.ready);
    endtask

    task automatic scan(input logic [NOW_W-1:0] now, input logic [ROW_LEVELS_W-1:0] rows);
        offer_item(CMD_SCAN, now, rows, KEY_INDEX_W'($urandom));
    endtask

    task automatic query(input logic [KEY_INDEX_W-1:0] idx);
        offer_item(CMD_QUERY, $urandom, ROW_LEVELS_W'($urandom), idx);
    endtask

    // Leaves the input channel quiet for the given number of cycles.
    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            scan_ch.valid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Stops offering and waits until every predicted result has been transferred out,
    // which also means the block holds no item any more.
    task automatic drain();
        @(negedge clk);
        scan_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // Registers are only ever written with the block empty.
    task automatic reconfigure(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_DEBOUNCE_MS)
            debounce_now = data[DEBOUNCE_W-1:0];
        else
            map_now = data[KEY_MAP_W-1:0];
    endtask

    // A key map in which most keys land on real matrix positions; now and then an entry
    // points outside the matrix so that the key is never scanned.
    function automatic logic [KEY_MAP_W-1:0] scattered_map();
        logic [KEY_MAP_W-1:0]   map;
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
        for (int k = 0; k < MAP_ENTRIES; k++)
        begin
            if ($urandom_range(0, 7) != 0)
            begin
                row = ROW_FIELD_W'($urandom_range(0, ROWS_DEFAULT - 1));
                col = COL_FIELD_W'($urandom_range(0, COLUMNS_DEFAULT - 1));
            end
            else
            begin
                row = ROW_FIELD_W'($urandom);
                col = COL_FIELD_W'($urandom);
            end
            map[ENTRY_W*k +: ENTRY_W] = {col, row};
        end
        return map;
    endfunction

    // Row-level bit that a key reads under the current map, or -1 if it is not scanned.
    function automatic int key_bit(input int k);
        logic [ENTRY_W-1:0] entry;
        entry = map_now[ENTRY_W*k +: ENTRY_W];
        if (entry[ROW_FIELD_W-1:0] >= ROWS_DEFAULT
            || entry[ENTRY_W-1 -: COL_FIELD_W] >= COLUMNS_DEFAULT)
            return -1;
        return entry[ENTRY_W-1 -: COL_FIELD_W] * ROWS_DEFAULT + entry[ROW_FIELD_W-1:0];
    endfunction

    // Bit to disturb: usually one that a mapped key reads, otherwise any row bit.
    function automatic int contact_bit();
        int b;
        b = key_bit($urandom_range(0, MAP_ENTRIES - 1));
        if (b < 0)
            b = $urandom_range(0, ROW_LEVELS_W - 1);
        return b;
    endfunction

    // One random item. Most are scans of a plausible keypad: time moves on by amounts
    // comparable to the debounce time, contacts change now and then, and a bouncing
    // contact shows up as a single flipped sample. The rest are queries and pure noise.
    task automatic random_item();
        int                      pick;
        int                      step;
        int                      b;
        logic [ROW_LEVELS_W-1:0] sample;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            query(KEY_INDEX_W'($urandom_range(0, MAP_ENTRIES - 1)));
        else if (pick < 33)
            scan($urandom, ROW_LEVELS_W'($urandom));
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: step = $urandom_range(0, debounce_now / 4 + 2);
                5, 6, 7:       step = $urandom_range(debounce_now / 2, debounce_now + 2);
                8:             step = debounce_now;
                default:       step = (debounce_now == 0) ? 0 : debounce_now - 1;
            endcase
            scan_clock_ms = scan_clock_ms + step;
            if ($urandom_range(0, 4) == 0)
            begin
                b = contact_bit();
                contact_rows[b] = ~contact_rows[b];
            end
            sample = contact_rows;
            if ($urandom_range(0, 5) == 0)
            begin
                b = contact_bit();
                sample[b] = ~sample[b];
            end
            scan(scan_clock_ms, sample);
        end
    endtask

    // Receiver: ready follows a pattern that changes after a random span, from always
    // ready to mostly stalled. On request it holds off for a long stretch while the sender
    // keeps going, so that both stages of the block fill and scan_in drops ready.
    initial
    begin
        int span;
        int style;
        result_ch.ready = 1'b0;
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(5, 40);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_off_request)
                begin
                    result_ch.ready <= 1'b0;
                    hold_off_request = 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge clk);
                end
                case (style)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= $urandom_range(0, 1);
                    2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Main stimulus.
    initial
    begin
        int                   phase_items [PHASES];
        int                   burst_left;
        logic [KEY_MAP_W-1:0] split_map;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_DEBOUNCE_MS;
        cfg_data           = '0;
        scan_ch.valid      = 1'b0;
        scan_ch.command    = CMD_SCAN;
        scan_ch.now_ms     = '0;
        scan_ch.row_levels = '1;
        scan_ch.key_index  = '0;
        debounce_now       = DEBOUNCE_RESET;
        map_now            = KEY_MAP_RESET;
        scan_clock_ms      = '0;
        contact_rows       = '1;
        phase_items        = '{150, 130, 120, 130, 40, 150};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, under the reset configuration first. A query straight out of reset
        // sees no press, with the time and row fields at their top value and key index zero.
        offer_item(CMD_QUERY, '1, '1, '0);
        offer_item(CMD_SCAN, '0, '1, '1);
        // All keys go low at 10 ms: one millisecond short of the debounce time nothing is
        // accepted, exactly on it every key settles low and latches a press.
        scan(32'd10, '0);
        scan(32'd59, '0);
        scan(32'd60, '0);
        // A press is reported once, then cleared.
        query(3'd0);
        query(3'd0);
        query(3'd7);
        // Release across the wrap of the millisecond counter.
        scan(32'hFFFF_FFF0, '1);
        scan(32'h0000_0021, '1);
        scan(32'h0000_0022, '1);

        // Zero debounce: a new level is accepted on the scan that first sees it.
        reconfigure(CFG_DEBOUNCE_MS, '0);
        scan(32'd100, '0);
        query(3'd3);

        // Every entry off the matrix: a scan leaves all keys as they were, and a press
        // latched earlier is still there to be read.
        reconfigure(CFG_KEY_MAP, '1);
        scan(32'd200, '1);
        query(3'd5);

        // Keys 0 to 3 off the matrix (row 6, row 7, column 3 twice), keys 4 to 7 on it.
        split_map = {5'b00100, 5'b01010, 5'b00000, 5'b10101,
                     5'b11010, 5'b11000, 5'b01111, 5'b00110};
        reconfigure(CFG_KEY_MAP, split_map);
        scan(32'd300, '1);

        // Longest debounce time, one short of it and then exactly on it.
        reconfigure(CFG_DEBOUNCE_MS, '1);
        scan(32'd400, '0);
        scan(32'd400 + 32'd65534, '0);
        scan(32'd400 + 32'd65535, '0);
        query(3'd4);

        // Random phases, each under its own configuration.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    reconfigure(CFG_DEBOUNCE_MS, CFG_DATA_W'(DEBOUNCE_RESET));
                    reconfigure(CFG_KEY_MAP, KEY_MAP_RESET);
                end
                1:
                begin
                    reconfigure(CFG_DEBOUNCE_MS, '0);
                    reconfigure(CFG_KEY_MAP, scattered_map());
                end
                2:
                begin
                    // Every key on the same contact, with the slowest debounce.
                    reconfigure(CFG_DEBOUNCE_MS, '1);
                    reconfigure(CFG_KEY_MAP, '0);
                end
                3:
                begin
                    reconfigure(CFG_DEBOUNCE_MS, CFG_DATA_W'($urandom_range(1, 8)));
                    reconfigure(CFG_KEY_MAP, scattered_map());
                end
                4:
                begin
                    reconfigure(CFG_DEBOUNCE_MS, CFG_DATA_W'($urandom_range(20, 200)));
                    reconfigure(CFG_KEY_MAP, '1);
                end
                default:
                begin
                    reconfigure(CFG_DEBOUNCE_MS, CFG_DATA_W'($urandom_range(10, 80)));
                    reconfigure(CFG_KEY_MAP, scattered_map());
                end
            endcase

            // Start either anywhere or just short of the counter wrapping round.
            if ($urandom_range(0, 1) == 0)
                scan_clock_ms = $urandom;
            else
                scan_clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * debounce_now + 100);

            burst_left = 0;
            if (phase == 0)
            begin
                // Receiver holds off while a long unbroken burst is offered.
                hold_off_request = 1'b1;
                burst_left       = 80;
            end

            for (int item = 0; item < phase_items[phase]; item++)
            begin
                if (phase == 3 && item == phase_items[phase] / 2)
                    drain();
                if (burst_left == 0)
                begin
                    pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 12);
                end
                random_item();
                burst_left--;
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
